>>> rtl/mi3_pkg.sv
`timescale 1ns / 1ps

package mi3_pkg;

    // Width of the singular tolerance register
    localparam int unsigned TOL_BITS = 31;

    // Elements in one 3x3 matrix
    localparam int unsigned NUM_ELEMS = 9;

    // Default word width, for units that follow the datapath
    localparam int unsigned DEF_WORD_BITS = 32;

    typedef logic [TOL_BITS-1:0] tol_t;

endpackage

>>> rtl/matrix_inverse_3x3_unit.sv
`timescale 1ns / 1ps

// 3x3 matrix inverse by the adjugate, signed fixed point (WORD_BITS wide, FRAC_BITS
// fraction bits, Q16.16 by default). One matrix is taken per cycle while the output
// is not stalled, and the results leave in order. Most of the pipeline is the nine
// restoring dividers, which work side by side and resolve one quotient bit per
// pipeline stage; the other seven stages form the products, cofactors and
// determinant and finish the result. When the output transaction is held by
// out_stall the whole pipeline holds, and in_stall is raised in the same cycle. A
// matrix whose exact determinant magnitude is at or below singular_tolerance
// (unsigned Q15.16, shifted to the determinant's scale) is flagged singular and
// gets a zero inverse; det_value is still given. Every output value saturates to
// the signed word, and overflow reports any saturation.
module matrix_inverse_3x3_unit
    import mi3_pkg::*;
#(
    parameter int FRAC_BITS = 16,
    parameter int WORD_BITS = 32
)
(
    input  logic                        clk,
    input  logic                        rst_n,

    input  logic                        cfg_write_en,
    input  tol_t                        cfg_write_data,

    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic signed [WORD_BITS-1:0] m00,
    input  logic signed [WORD_BITS-1:0] m01,
    input  logic signed [WORD_BITS-1:0] m02,
    input  logic signed [WORD_BITS-1:0] m10,
    input  logic signed [WORD_BITS-1:0] m11,
    input  logic signed [WORD_BITS-1:0] m12,
    input  logic signed [WORD_BITS-1:0] m20,
    input  logic signed [WORD_BITS-1:0] m21,
    input  logic signed [WORD_BITS-1:0] m22,

    output logic                        out_valid,
    input  logic                        out_stall,
    output logic signed [WORD_BITS-1:0] inv00,
    output logic signed [WORD_BITS-1:0] inv01,
    output logic signed [WORD_BITS-1:0] inv02,
    output logic signed [WORD_BITS-1:0] inv10,
    output logic signed [WORD_BITS-1:0] inv11,
    output logic signed [WORD_BITS-1:0] inv12,
    output logic signed [WORD_BITS-1:0] inv20,
    output logic signed [WORD_BITS-1:0] inv21,
    output logic signed [WORD_BITS-1:0] inv22,
    output logic signed [WORD_BITS-1:0] det_value,
    output logic                        singular,
    output logic                        overflow
);

    localparam int W     = WORD_BITS;
    localparam int SH    = 2 * FRAC_BITS;       // scale between cofactor and quotient
    localparam int PW    = 2 * W;               // element product
    localparam int CW    = 2 * W + 1;           // cofactor, and partial product of det
    localparam int DW    = 3 * W + 3;           // exact determinant
    localparam int NUMW  = CW + SH;             // |cofactor| shifted to the numerator
    localparam int RW0   = (NUMW > DW + W) ? NUMW : DW + W;
    localparam int RW    = RW0 + 1;             // divider remainder
    localparam int LW    = TOL_BITS + SH;       // tolerance at determinant scale
    localparam int CMPW  = (LW > DW) ? LW : DW;
    localparam int NS    = W + 7;               // stages that carry a valid bit

    // Cofactor i = m[a] * m[b] - m[c] * m[d], transposed order
    localparam int CIDX [NUM_ELEMS][4] = '{
        '{4, 8, 7, 5}, '{7, 2, 1, 8}, '{1, 5, 4, 2},
        '{6, 5, 3, 8}, '{0, 8, 6, 2}, '{3, 2, 0, 5},
        '{3, 7, 6, 4}, '{6, 1, 0, 7}, '{0, 4, 1, 3}
    };

    localparam logic [W-1:0] WORD_MAX = {1'b0, {(W-1){1'b1}}};
    localparam logic [W-1:0] WORD_MIN = {1'b1, {(W-1){1'b0}}};

    typedef struct packed {
        logic [DW-1:0]        dabs;
        logic [NUM_ELEMS-1:0] neg;
        logic [NUM_ELEMS-1:0] big;
        logic                 sing;
        logic [W-1:0]         det_word;
        logic                 det_ovf;
    } side_t;

    // ------------------------------------------------------------------
    // Configuration and flow control
    // ------------------------------------------------------------------
    tol_t            tol_reg;
    logic [NS-1:0]   vld_reg;
    logic            advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tol_reg <= '0;
        end
        else if (cfg_write_en)
        begin
            tol_reg <= cfg_write_data;
        end
    end

    // The pipeline moves as a whole unless the output transaction is held
    assign advance   = !vld_reg[NS-1] || !out_stall;
    assign in_stall  = !advance;
    assign out_valid = vld_reg[NS-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (advance)
        begin
            vld_reg <= {vld_reg[NS-2:0], in_valid};
        end
    end

    logic signed [W-1:0] m_in [NUM_ELEMS];

    assign m_in[0] = m00;
    assign m_in[1] = m01;
    assign m_in[2] = m02;
    assign m_in[3] = m10;
    assign m_in[4] = m11;
    assign m_in[5] = m12;
    assign m_in[6] = m20;
    assign m_in[7] = m21;
    assign m_in[8] = m22;

    // ------------------------------------------------------------------
    // Stage 0: the eighteen element products of the cofactors
    // ------------------------------------------------------------------
    logic signed [PW-1:0] s0_prod_next [2*NUM_ELEMS];
    logic signed [PW-1:0] s0_prod_reg  [2*NUM_ELEMS];
    logic signed [W-1:0]  s0_row_reg   [3];

    always_comb
    begin
        for (int i = 0; i < NUM_ELEMS; i++)
        begin
            s0_prod_next[2*i]   = PW'(m_in[CIDX[i][0]]) * PW'(m_in[CIDX[i][1]]);
            s0_prod_next[2*i+1] = PW'(m_in[CIDX[i][2]]) * PW'(m_in[CIDX[i][3]]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s0_prod_reg <= s0_prod_next;
            for (int k = 0; k < 3; k++)
            begin
                s0_row_reg[k] <= m_in[k];
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: cofactors
    // ------------------------------------------------------------------
    logic signed [CW-1:0] s1_cof_next [NUM_ELEMS];
    logic signed [CW-1:0] s1_cof_reg  [NUM_ELEMS];
    logic signed [W-1:0]  s1_row_reg  [3];

    always_comb
    begin
        for (int i = 0; i < NUM_ELEMS; i++)
        begin
            s1_cof_next[i] = CW'(s0_prod_reg[2*i]) - CW'(s0_prod_reg[2*i+1]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s1_cof_reg <= s1_cof_next;
            s1_row_reg <= s0_row_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: first-row element times cofactor, cut into low and high halves
    // ------------------------------------------------------------------
    logic signed [CW-1:0] s2_plo_next [3];
    logic signed [CW-1:0] s2_phi_next [3];
    logic signed [CW-1:0] s2_plo_reg  [3];
    logic signed [CW-1:0] s2_phi_reg  [3];
    logic signed [CW-1:0] s2_cof_reg  [NUM_ELEMS];

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            s2_plo_next[k] = CW'(s1_row_reg[k])
                           * CW'($signed({1'b0, s1_cof_reg[3*k][W-1:0]}));
            s2_phi_next[k] = CW'(s1_row_reg[k])
                           * CW'($signed(s1_cof_reg[3*k][CW-1:W]));
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s2_plo_reg <= s2_plo_next;
            s2_phi_reg <= s2_phi_next;
            s2_cof_reg <= s1_cof_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 3: exact determinant
    // ------------------------------------------------------------------
    logic signed [DW-1:0] s3_det_next;
    logic signed [DW-1:0] s3_det_reg;
    logic signed [CW-1:0] s3_cof_reg [NUM_ELEMS];

    always_comb
    begin
        s3_det_next = '0;
        for (int k = 0; k < 3; k++)
        begin
            s3_det_next = s3_det_next + (DW'(s2_phi_reg[k]) <<< W) + DW'(s2_plo_reg[k]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s3_det_reg <= s3_det_next;
            s3_cof_reg <= s2_cof_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 4: magnitudes, quotient signs, rounded and saturated det_value
    // ------------------------------------------------------------------
    logic                 det_neg;
    logic signed [DW-1:0] det_sh;
    logic                 det_fit;
    logic [CW-1:0]        cof_abs [NUM_ELEMS];

    logic [DW-1:0]        s4_dabs_next;
    logic [NUMW-1:0]      s4_num_next [NUM_ELEMS];
    logic [NUM_ELEMS-1:0] s4_neg_next;
    logic [W-1:0]         s4_dword_next;
    logic                 s4_dovf_next;

    logic [DW-1:0]        s4_dabs_reg;
    logic [NUMW-1:0]      s4_num_reg [NUM_ELEMS];
    logic [NUM_ELEMS-1:0] s4_neg_reg;
    logic [W-1:0]         s4_dword_reg;
    logic                 s4_dovf_reg;

    always_comb
    begin
        det_neg      = s3_det_reg[DW-1];
        s4_dabs_next = det_neg ? DW'(-s3_det_reg) : DW'(s3_det_reg);
        for (int i = 0; i < NUM_ELEMS; i++)
        begin
            cof_abs[i]     = s3_cof_reg[i][CW-1] ? CW'(-s3_cof_reg[i]) : CW'(s3_cof_reg[i]);
            s4_num_next[i] = NUMW'(cof_abs[i]) << SH;
            s4_neg_next[i] = s3_cof_reg[i][CW-1] ^ det_neg;
        end
        // Floor shift: arithmetic shift rounds toward minus infinity
        det_sh  = s3_det_reg >>> SH;
        det_fit = (det_sh[DW-1:W-1] == '0) || (det_sh[DW-1:W-1] == '1);
        s4_dovf_next  = !det_fit;
        s4_dword_next = det_fit ? det_sh[W-1:0] : (det_sh[DW-1] ? WORD_MIN : WORD_MAX);
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s4_dabs_reg  <= s4_dabs_next;
            s4_num_reg   <= s4_num_next;
            s4_neg_reg   <= s4_neg_next;
            s4_dword_reg <= s4_dword_next;
            s4_dovf_reg  <= s4_dovf_next;
        end
    end

    // ------------------------------------------------------------------
    // Stage 5: singular test, quotient range check, divider load
    // ------------------------------------------------------------------
    logic [W-1:0]  q_reg   [W+1][NUM_ELEMS];
    logic [RW-1:0] rem_reg [W][NUM_ELEMS];
    side_t         side_reg [W+1];
    side_t         s5_side_next;
    logic [CMPW-1:0] lim_cmp;

    always_comb
    begin
        lim_cmp = CMPW'(tol_reg) << SH;
        s5_side_next.dabs     = s4_dabs_reg;
        s5_side_next.neg      = s4_neg_reg;
        s5_side_next.sing     = CMPW'(s4_dabs_reg) <= lim_cmp;
        s5_side_next.det_word = s4_dword_reg;
        s5_side_next.det_ovf  = s4_dovf_reg;
        // Quotient of 2^W or more saturates whatever its sign
        for (int i = 0; i < NUM_ELEMS; i++)
        begin
            s5_side_next.big[i] = RW'(s4_num_reg[i]) >= (RW'(s4_dabs_reg) << W);
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            side_reg[0] <= s5_side_next;
            for (int i = 0; i < NUM_ELEMS; i++)
            begin
                rem_reg[0][i] <= RW'(s4_num_reg[i]);
                q_reg[0][i]   <= '0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Divider stages: one quotient bit per stage, most significant first
    // ------------------------------------------------------------------
    for (genvar j = 0; j < W; j++)
    begin : g_div
        localparam int KB = W - 1 - j;

        logic [RW-1:0] dsh;
        logic [RW:0]   diff     [NUM_ELEMS];
        logic [RW-1:0] rem_next [NUM_ELEMS];
        logic [W-1:0]  q_next   [NUM_ELEMS];

        always_comb
        begin
            dsh = RW'(side_reg[j].dabs) << KB;
            for (int i = 0; i < NUM_ELEMS; i++)
            begin
                diff[i]     = {1'b0, rem_reg[j][i]} - {1'b0, dsh};
                rem_next[i] = diff[i][RW] ? rem_reg[j][i] : diff[i][RW-1:0];
                q_next[i]   = q_reg[j][i];
                q_next[i][KB] = !diff[i][RW];
            end
        end

        always_ff @(posedge clk)
        begin
            if (advance)
            begin
                q_reg[j+1]    <= q_next;
                side_reg[j+1] <= side_reg[j];
            end
        end

        if (j < W - 1)
        begin : g_rem
            always_ff @(posedge clk)
            begin
                if (advance)
                begin
                    rem_reg[j+1] <= rem_next;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Output stage: apply sign, saturate, zero a singular inverse
    // ------------------------------------------------------------------
    logic [W-1:0]         fin_mag;
    logic                 fin_neg;
    logic [NUM_ELEMS-1:0] fin_ovf;
    logic [W-1:0]         inv_next [NUM_ELEMS];
    logic                 ovf_next;
    logic [W-1:0]         inv_reg  [NUM_ELEMS];
    logic [W-1:0]         det_reg;
    logic                 sing_reg;
    logic                 ovf_reg;

    always_comb
    begin
        for (int i = 0; i < NUM_ELEMS; i++)
        begin
            fin_mag = q_reg[W][i];
            fin_neg = side_reg[W].neg[i];
            // Negative side reaches one step further than the positive side
            if (fin_neg)
            begin
                fin_ovf[i] = side_reg[W].big[i] || (fin_mag[W-1] && (fin_mag[W-2:0] != '0));
            end
            else
            begin
                fin_ovf[i] = side_reg[W].big[i] || fin_mag[W-1];
            end
            if (side_reg[W].sing)
            begin
                inv_next[i] = '0;
            end
            else if (fin_ovf[i])
            begin
                inv_next[i] = fin_neg ? WORD_MIN : WORD_MAX;
            end
            else
            begin
                inv_next[i] = fin_neg ? W'(-fin_mag) : fin_mag;
            end
        end
        ovf_next = side_reg[W].det_ovf || (!side_reg[W].sing && (fin_ovf != '0));
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            inv_reg  <= inv_next;
            det_reg  <= side_reg[W].det_word;
            sing_reg <= side_reg[W].sing;
            ovf_reg  <= ovf_next;
        end
    end

    assign inv00     = inv_reg[0];
    assign inv01     = inv_reg[1];
    assign inv02     = inv_reg[2];
    assign inv10     = inv_reg[3];
    assign inv11     = inv_reg[4];
    assign inv12     = inv_reg[5];
    assign inv20     = inv_reg[6];
    assign inv21     = inv_reg[7];
    assign inv22     = inv_reg[8];
    assign det_value = det_reg;
    assign singular  = sing_reg;
    assign overflow  = ovf_reg;

endmodule

>>> rtl/mi3_checker.sv
`timescale 1ns / 1ps

module mi3_checker
    import mi3_pkg::*;
#(
    parameter int WORD_BITS = DEF_WORD_BITS
)
(
    input logic                        clk,
    input logic                        rst_n,
    input logic                        in_stall,
    input logic                        out_valid,
    input logic                        out_stall,
    input logic signed [WORD_BITS-1:0] inv00,
    input logic signed [WORD_BITS-1:0] inv01,
    input logic signed [WORD_BITS-1:0] inv02,
    input logic signed [WORD_BITS-1:0] inv10,
    input logic signed [WORD_BITS-1:0] inv11,
    input logic signed [WORD_BITS-1:0] inv12,
    input logic signed [WORD_BITS-1:0] inv20,
    input logic signed [WORD_BITS-1:0] inv21,
    input logic signed [WORD_BITS-1:0] inv22,
    input logic signed [WORD_BITS-1:0] det_value,
    input logic                        singular,
    input logic                        overflow
);

    // Hold a stalled result transaction
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("result transaction dropped while stalled");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> $stable(inv00) && $stable(inv11) && $stable(inv22)
            && $stable(det_value) && $stable(singular) && $stable(overflow))
        else $error("stalled result transaction changed");

    // Input side stalls only behind a held result
    a_in_stall: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid && out_stall)
        else $error("input stalled without a held result");

    // Singular matrix gives a zero inverse
    a_sing_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && singular |-> (inv00 == '0) && (inv01 == '0) && (inv02 == '0)
            && (inv10 == '0) && (inv11 == '0) && (inv12 == '0)
            && (inv20 == '0) && (inv21 == '0) && (inv22 == '0))
        else $error("singular result with non-zero inverse");

endmodule

bind matrix_inverse_3x3_unit mi3_checker #(.WORD_BITS(WORD_BITS)) u_mi3_checker (.*);
